// File: rtl/sccl_pkg.sv
// Shared types and constants for the serial CAN command line parser.
// Used by sccl_front, sccl_back and serial_can_command_line_parser; depends on nothing.
package sccl_pkg;

  localparam int LINE_CAPACITY = 200;
  localparam int STORE_DEPTH   = 26;
  localparam int LEN_W         = $clog2(LINE_CAPACITY + 1);
  localparam int POS_W         = $clog2(STORE_DEPTH);

  // Class of a received byte, worked out by the front part.
  typedef enum logic [1:0] {
    KIND_PRINT,
    KIND_ERASE,
    KIND_EOL,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } entry_t;

  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_ACK  = 2'd1;
  localparam logic [1:0] REPLY_NACK = 2'd2;

  localparam logic [1:0] BUS_NONE  = 2'd0;
  localparam logic [1:0] BUS_SET   = 2'd1;
  localparam logic [1:0] BUS_OPEN  = 2'd2;
  localparam logic [1:0] BUS_CLOSE = 2'd3;

  typedef struct packed {
    logic [1:0]  reply;
    logic        send_frame;
    logic        extended_id;
    logic        remote_request;
    logic [31:0] frame_id;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
    logic [1:0]  bus_action;
    logic [3:0]  bitrate_index;
    logic        silent_mode;
    logic        loopback_mode;
    logic        timestamp_on;
  } result_t;

endpackage

// File: rtl/serial_can_command_line_parser.sv
// Top level of the serial CAN command line parser (ASCII adapter command set).
// Depends on sccl_pkg, sccl_front and sccl_back.
//
//   Channel   Signals                         Word
//   input     rx_valid, rx_ready, rx_byte     one received serial byte
//   output    res_valid, res_ready, fields    one decoded reply per carriage return
//
// Printable, erase and clearing bytes are applied to the line in the back part's idle state.
// A carriage return starts a walk of the line: the line store has a single read port and
// the back part walks all 26 stored positions, one a cycle, then loads the result
// register in its emit state once that register is free. The input side keeps accepting
// bytes into a two-word queue meanwhile, and a finished result may wait in the output
// register while the next bytes are taken. Reset is synchronous and clears the
// line, the queue and the flags (timestamping comes up enabled).
module serial_can_command_line_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_ready,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  reply,
  output logic        send_frame,
  output logic        extended_id,
  output logic        remote_request,
  output logic [31:0] frame_id,
  output logic [3:0]  frame_length,
  output logic [63:0] frame_data,
  output logic [1:0]  bus_action,
  output logic [3:0]  bitrate_index,
  output logic        silent_mode,
  output logic        loopback_mode,
  output logic        timestamp_on
);
  import sccl_pkg::*;

  // Classified bytes between the front and the back part.
  logic    q_valid;
  logic    q_ready;
  entry_t  q_item;
  result_t res;

  // The front part only classifies and buffers; it holds off bytes only while its queue is full.
  sccl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_ready (rx_ready),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // The back part owns the line and the mode flags and builds each reply.
  sccl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The result register is split out into the individual output fields.
  assign reply          = res.reply;
  assign send_frame     = res.send_frame;
  assign extended_id    = res.extended_id;
  assign remote_request = res.remote_request;
  assign frame_id       = res.frame_id;
  assign frame_length   = res.frame_length;
  assign frame_data     = res.frame_data;
  assign bus_action     = res.bus_action;
  assign bitrate_index  = res.bitrate_index;
  assign silent_mode    = res.silent_mode;
  assign loopback_mode  = res.loopback_mode;
  assign timestamp_on   = res.timestamp_on;

endmodule

// File: rtl/sccl_front.sv
// Front part: accepts serial bytes, classifies them and queues them in a two-word buffer.
// Depends on sccl_pkg.
module sccl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            rx_valid,
  output logic            rx_ready,
  input  logic [7:0]      rx_byte,
  output logic            q_valid,
  input  logic            q_ready,
  output sccl_pkg::entry_t q_item
);
  import sccl_pkg::*;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  entry_t     slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  entry_t     incoming;
  logic       push;
  logic       pop;

  always_comb begin
    incoming.ch = rx_byte;
    if (rx_byte >= CH_SPACE && rx_byte <= CH_TILDE) begin
      incoming.kind = KIND_PRINT;
    end else if (rx_byte == CH_BS || rx_byte == CH_DEL) begin
      incoming.kind = KIND_ERASE;
    end else if (rx_byte == CH_CR) begin
      incoming.kind = KIND_EOL;
    end else begin
      incoming.kind = KIND_CLEAR;
    end
  end

  assign rx_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];
  assign push     = rx_valid && rx_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
  end

endmodule

// File: rtl/sccl_back.sv
// Back part: keeps the command line, walks it on a carriage return and registers the result.
// Depends on sccl_pkg.
module sccl_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  sccl_pkg::entry_t  q_item,
  output logic              res_valid,
  input  logic              res_ready,
  output sccl_pkg::result_t res
);
  import sccl_pkg::*;

  localparam logic [7:0] CMD_EXT_FRAME = "T";
  localparam logic [7:0] CMD_STD_FRAME = "t";
  localparam logic [7:0] CMD_EXT_RTR   = "R";
  localparam logic [7:0] CMD_STD_RTR   = "r";
  localparam logic [7:0] CMD_BITRATE   = "S";
  localparam logic [7:0] CMD_BITRATE_L = "s";
  localparam logic [7:0] CMD_OPEN      = "O";
  localparam logic [7:0] CMD_CLOSE     = "C";
  localparam logic [7:0] CMD_SILENT    = "L";
  localparam logic [7:0] CMD_LOOPBACK  = "l";
  localparam logic [7:0] CMD_TSTAMP    = "Z";
  localparam logic [7:0] CMD_MASK      = "M";
  localparam logic [7:0] CMD_MASK_L    = "m";
  localparam logic [7:0] CMD_DUAL      = "D";
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(STORE_DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_t;

  state_t           state;
  logic [7:0]       line_store [STORE_DEPTH];
  logic [LEN_W-1:0] line_len;
  logic             silent_flag;
  logic             loopback_flag;
  logic             timestamp_flag;

  logic [POS_W-1:0] walk_pos;
  logic [7:0]       cmd;
  logic [31:0]      id;
  logic [3:0]       dlc;
  logic             dlc_bad;
  logic             bad;
  logic [63:0]      data;
  logic [3:0]       v1;
  logic             v1_bad;

  logic [7:0]       cur_ch;
  logic [3:0]       hv;
  logic             hbad;
  logic             is_ext;
  logic             is_rtr;
  logic [POS_W-1:0] digits;
  logic [POS_W-1:0] dlc_pos;
  logic [POS_W-1:0] data_base;
  logic [POS_W-1:0] nib_k;
  logic             in_id;
  logic             in_data;
  logic [5:0]       nib_off;

  result_t          res_next;
  logic             silent_next;
  logic             loopback_next;
  logic             timestamp_next;

  assign q_ready = (state == ST_IDLE);

  // Character at the walk position; positions past the line end read as zero.
  assign cur_ch = (LEN_W'(walk_pos) < line_len) ? line_store[walk_pos] : 8'd0;

  always_comb begin
    hbad = 1'b0;
    hv   = 4'd0;
    if (cur_ch >= "0" && cur_ch <= "9") begin
      hv = 4'(cur_ch - "0");
    end else if (cur_ch >= "a" && cur_ch <= "f") begin
      hv = 4'(cur_ch - "a" + 8'd10);
    end else if (cur_ch >= "A" && cur_ch <= "F") begin
      hv = 4'(cur_ch - "A" + 8'd10);
    end else begin
      hbad = 1'b1;
    end
  end

  assign is_ext    = (cmd == CMD_EXT_FRAME) || (cmd == CMD_EXT_RTR);
  assign is_rtr    = (cmd == CMD_EXT_RTR) || (cmd == CMD_STD_RTR);
  assign digits    = is_ext ? POS_W'(8) : POS_W'(3);
  assign dlc_pos   = digits + POS_W'(1);
  assign data_base = digits + POS_W'(2);
  assign nib_k     = walk_pos - data_base;
  assign in_id     = (walk_pos != '0) && (walk_pos <= digits);
  assign in_data   = !is_rtr && (walk_pos >= data_base) && (5'(nib_k) < {dlc, 1'b0});
  // Even nibble is the high half of its byte.
  assign nib_off   = {nib_k[3:1], ~nib_k[0], 2'b00};

  // Decode of the walked line into a result and the flags that follow it.
  always_comb begin
    res_next       = '0;
    silent_next    = silent_flag;
    loopback_next  = loopback_flag;
    timestamp_next = timestamp_flag;
    if (line_len != '0) begin
      case (cmd)
        CMD_EXT_FRAME, CMD_STD_FRAME, CMD_EXT_RTR, CMD_STD_RTR: begin
          if (!bad && !dlc_bad) begin
            res_next.reply          = REPLY_ACK;
            res_next.send_frame     = 1'b1;
            res_next.extended_id    = is_ext;
            res_next.remote_request = is_rtr;
            res_next.frame_id       = id;
            res_next.frame_length   = dlc;
            res_next.frame_data     = data;
          end else begin
            res_next.reply = REPLY_NACK;
          end
        end
        CMD_BITRATE, CMD_BITRATE_L: begin
          if (line_len != LEN_W'(2)) begin
            res_next.reply = REPLY_NONE;
          end else if (v1_bad || v1 > 4'd8) begin
            res_next.reply = REPLY_NACK;
          end else begin
            res_next.reply         = REPLY_ACK;
            res_next.bus_action    = BUS_SET;
            res_next.bitrate_index = v1;
          end
        end
        CMD_OPEN: begin
          silent_next         = 1'b0;
          loopback_next       = 1'b0;
          res_next.reply      = REPLY_ACK;
          res_next.bus_action = BUS_OPEN;
        end
        CMD_CLOSE: begin
          silent_next         = 1'b0;
          loopback_next       = 1'b0;
          res_next.reply      = REPLY_ACK;
          res_next.bus_action = BUS_CLOSE;
        end
        CMD_SILENT: begin
          silent_next         = 1'b1;
          res_next.reply      = REPLY_ACK;
          res_next.bus_action = BUS_OPEN;
        end
        CMD_LOOPBACK: begin
          loopback_next       = 1'b1;
          res_next.reply      = REPLY_ACK;
          res_next.bus_action = BUS_OPEN;
        end
        CMD_TSTAMP: begin
          if (line_len != LEN_W'(2)) begin
            res_next.reply = REPLY_NONE;
          end else if (v1_bad || v1 > 4'd1) begin
            res_next.reply = REPLY_NACK;
          end else begin
            timestamp_next = v1[0];
            res_next.reply = REPLY_ACK;
          end
        end
        CMD_MASK, CMD_MASK_L, CMD_DUAL: begin
          res_next.reply = REPLY_NACK;
        end
        default: begin
          res_next.reply = REPLY_NONE;
        end
      endcase
    end
    res_next.silent_mode   = silent_next;
    res_next.loopback_mode = loopback_next;
    res_next.timestamp_on  = timestamp_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      line_len       <= '0;
      silent_flag    <= 1'b0;
      loopback_flag  <= 1'b0;
      timestamp_flag <= 1'b1;
      res_valid      <= 1'b0;
    end else begin
      // In the emit state the result register is refilled instead.
      if (res_valid && res_ready && state != ST_EMIT) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_item.kind)
              KIND_PRINT: begin
                if (line_len < LEN_W'(LINE_CAPACITY)) begin
                  line_len <= line_len + LEN_W'(1);
                end else begin
                  line_len <= '0;
                end
              end
              KIND_ERASE: begin
                if (line_len != '0) begin
                  line_len <= line_len - LEN_W'(1);
                end
              end
              KIND_EOL: begin
                state    <= ST_WALK;
                walk_pos <= '0;
                id       <= '0;
                dlc      <= '0;
                dlc_bad  <= 1'b0;
                bad      <= 1'b0;
                data     <= '0;
                v1       <= '0;
                v1_bad   <= 1'b0;
              end
              default: begin
                line_len <= '0;
              end
            endcase
          end
        end
        ST_WALK: begin
          if (walk_pos == '0) begin
            cmd <= cur_ch;
          end
          if (walk_pos == POS_W'(1)) begin
            v1     <= hv;
            v1_bad <= hbad;
          end
          if (in_id) begin
            id <= {id[27:0], hv};
            if (hbad) begin
              bad <= 1'b1;
            end
          end
          if (walk_pos == dlc_pos) begin
            if (is_ext && !is_rtr) begin
              dlc     <= hv;
              dlc_bad <= hbad || (hv > 4'd8);
            end else begin
              dlc     <= 4'(cur_ch - "0");
              dlc_bad <= !(cur_ch >= "0" && cur_ch <= "8");
            end
          end
          if (walk_pos != '0 && walk_pos > dlc_pos && in_data) begin
            data[nib_off +: 4] <= hv;
            if (hbad) begin
              bad <= 1'b1;
            end
          end
          if (walk_pos == LAST_POS) begin
            state <= ST_EMIT;
          end else begin
            walk_pos <= walk_pos + POS_W'(1);
          end
        end
        ST_EMIT: begin
          if (!res_valid || res_ready) begin
            res            <= res_next;
            res_valid      <= 1'b1;
            silent_flag    <= silent_next;
            loopback_flag  <= loopback_next;
            timestamp_flag <= timestamp_next;
            line_len       <= '0;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_item.kind == KIND_PRINT &&
        line_len < LEN_W'(STORE_DEPTH)) begin
      line_store[line_len[POS_W-1:0]] <= q_item.ch;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    line_len <= LEN_W'(LINE_CAPACITY))
    else $error("line length beyond capacity");

  a_eol_starts_walk: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE && q_valid && q_item.kind == KIND_EOL |=>
      state == ST_WALK && walk_pos == '0)
    else $error("carriage return did not start the line walk");

  a_walk_runs: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK && walk_pos != LAST_POS |=> state == ST_WALK)
    else $error("line walk ended early");

  a_frame_acked: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.send_frame |-> res.reply == REPLY_ACK && res.bus_action == BUS_NONE)
    else $error("frame result without acknowledge");

  a_bitrate_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.bus_action != BUS_SET |-> res.bitrate_index == '0)
    else $error("bitrate index set without bitrate action");

endmodule

// File: tb/sccl_reply_checker.sv
// Character constants and the reply checker for the serial CAN command line parser bench.
// Depends on sccl_pkg; the checker predicts every reply word and compares it with the block.
package sccl_tb_pkg;

  localparam logic [7:0] CH_BS          = 8'h08;
  localparam logic [7:0] CH_CR          = 8'h0D;
  localparam logic [7:0] CH_ESC         = 8'h1B;
  localparam logic [7:0] CH_DEL         = 8'h7F;
  localparam logic [7:0] CH_FIRST_PRINT = 8'h20;
  localparam logic [7:0] CH_LAST_PRINT  = 8'h7E;

  localparam logic [7:0] CMD_TX_EXT       = "T";
  localparam logic [7:0] CMD_TX_STD       = "t";
  localparam logic [7:0] CMD_RTR_EXT      = "R";
  localparam logic [7:0] CMD_RTR_STD      = "r";
  localparam logic [7:0] CMD_BITRATE      = "S";
  localparam logic [7:0] CMD_BITRATE_ALT  = "s";
  localparam logic [7:0] CMD_OPEN         = "O";
  localparam logic [7:0] CMD_CLOSE        = "C";
  localparam logic [7:0] CMD_LISTEN       = "L";
  localparam logic [7:0] CMD_LOOPBACK     = "l";
  localparam logic [7:0] CMD_TIMESTAMP    = "Z";
  localparam logic [7:0] CMD_ACCEPT_CODE  = "M";
  localparam logic [7:0] CMD_ACCEPT_MASK  = "m";
  localparam logic [7:0] CMD_D_REFUSED    = "D";

  localparam int MAX_DLC     = 8;
  localparam int MAX_BITRATE = 8;

endpackage

module sccl_reply_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  input  logic        rx_ready,
  input  logic [7:0]  rx_byte,
  input  logic        res_valid,
  input  logic        res_ready,
  input  logic [1:0]  reply,
  input  logic        send_frame,
  input  logic        extended_id,
  input  logic        remote_request,
  input  logic [31:0] frame_id,
  input  logic [3:0]  frame_length,
  input  logic [63:0] frame_data,
  input  logic [1:0]  bus_action,
  input  logic [3:0]  bitrate_index,
  input  logic        silent_mode,
  input  logic        loopback_mode,
  input  logic        timestamp_on,
  output int unsigned mismatches,
  output int unsigned awaiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import sccl_pkg::*;
  import sccl_tb_pkg::*;

  logic [7:0]  line_chars [STORE_DEPTH];
  int unsigned line_len;
  logic        silent;
  logic        loopback;
  logic        tstamp;
  result_t     expected_replies [$];
  int unsigned errors;

  assign mismatches = errors;

  function automatic logic [7:0] char_at(input int unsigned pos);
    if (pos < line_len && pos < STORE_DEPTH) return line_chars[pos];
    return 8'h00;
  endfunction

  function automatic logic [3:0] hex_at(input int unsigned pos, inout bit bad);
    logic [7:0] c;
    c = char_at(pos);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    bad = 1'b1;
    return 4'd0;
  endfunction

  // Fills r.reply and, on success, the frame fields.
  function automatic void decode_frame(input bit ext, input bit rtr, inout result_t r);
    bit          bad;
    int unsigned digits;
    int unsigned dlc;
    int unsigned i;
    logic [31:0] id;
    logic [63:0] data;
    logic [7:0]  c;
    bad    = 1'b0;
    digits = ext ? 8 : 3;
    id     = '0;
    data   = '0;
    r.reply = REPLY_NACK;
    for (i = 0; i < digits; i++) id = {id[27:0], hex_at(1 + i, bad)};
    if (ext && !rtr) begin
      dlc = 32'(hex_at(digits + 1, bad));
      if (bad || dlc > MAX_DLC) return;
    end else begin
      c = char_at(digits + 1);
      if (c < "0" || c > "8") return;
      dlc = 32'(c - "0");
    end
    if (rtr) begin
      if (line_len < digits + 2) return;
    end else begin
      if (line_len < digits + 2 + 2 * dlc) return;
      for (i = 0; i < dlc; i++)
        data[8*i +: 8] = {hex_at(digits + 2 + 2 * i, bad), hex_at(digits + 3 + 2 * i, bad)};
    end
    if (bad) return;
    r.reply          = REPLY_ACK;
    r.send_frame     = 1'b1;
    r.extended_id    = ext;
    r.remote_request = rtr;
    r.frame_id       = id;
    r.frame_length   = 4'(dlc);
    r.frame_data     = data;
  endfunction

  function automatic result_t decode_line();
    result_t    r;
    bit         bad;
    logic [3:0] v;
    r   = '0;
    bad = 1'b0;
    r.reply = REPLY_NONE;
    case (char_at(0))
      CMD_TX_EXT:  decode_frame(1'b1, 1'b0, r);
      CMD_TX_STD:  decode_frame(1'b0, 1'b0, r);
      CMD_RTR_EXT: decode_frame(1'b1, 1'b1, r);
      CMD_RTR_STD: decode_frame(1'b0, 1'b1, r);
      CMD_BITRATE, CMD_BITRATE_ALT: begin
        if (line_len == 2) begin
          v = hex_at(1, bad);
          if (bad || v > MAX_BITRATE) begin
            r.reply = REPLY_NACK;
          end else begin
            r.reply         = REPLY_ACK;
            r.bus_action    = BUS_SET;
            r.bitrate_index = v;
          end
        end
      end
      CMD_OPEN, CMD_CLOSE: begin
        silent       = 1'b0;
        loopback     = 1'b0;
        r.reply      = REPLY_ACK;
        r.bus_action = (char_at(0) == CMD_OPEN) ? BUS_OPEN : BUS_CLOSE;
      end
      CMD_LISTEN: begin
        silent       = 1'b1;
        r.reply      = REPLY_ACK;
        r.bus_action = BUS_OPEN;
      end
      CMD_LOOPBACK: begin
        loopback     = 1'b1;
        r.reply      = REPLY_ACK;
        r.bus_action = BUS_OPEN;
      end
      CMD_TIMESTAMP: begin
        if (line_len == 2) begin
          v = hex_at(1, bad);
          if (bad || v > 1) begin
            r.reply = REPLY_NACK;
          end else begin
            tstamp  = v[0];
            r.reply = REPLY_ACK;
          end
        end
      end
      CMD_ACCEPT_CODE, CMD_ACCEPT_MASK, CMD_D_REFUSED: r.reply = REPLY_NACK;
      default: r.reply = REPLY_NONE;
    endcase
    r.silent_mode   = silent;
    r.loopback_mode = loopback;
    r.timestamp_on  = tstamp;
    return r;
  endfunction

  // Applies one received byte to the line; returns 1 when a reply word follows.
  function automatic bit take_byte(input logic [7:0] b, output result_t r);
    r = '0;
    if (b >= CH_FIRST_PRINT && b <= CH_LAST_PRINT) begin
      if (line_len < LINE_CAPACITY) begin
        if (line_len < STORE_DEPTH) line_chars[line_len] = b;
        line_len++;
      end else begin
        line_len = 0;
      end
      return 1'b0;
    end
    if (b == CH_BS || b == CH_DEL) begin
      if (line_len > 0) line_len--;
      return 1'b0;
    end
    if (b != CH_CR) begin
      line_len = 0;
      return 1'b0;
    end
    r = decode_line();
    line_len = 0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    result_t seen;
    result_t want;
    result_t made;
    if (rst) begin
      line_len = 0;
      silent   = 1'b0;
      loopback = 1'b0;
      tstamp   = 1'b1;
      errors   = 0;
      expected_replies.delete();
      awaiting <= 0;
    end else begin
      if (res_valid && res_ready) begin
        seen = {reply, send_frame, extended_id, remote_request, frame_id, frame_length,
                frame_data, bus_action, bitrate_index, silent_mode, loopback_mode,
                timestamp_on};
        if (expected_replies.size() == 0) begin
          $error("reply word with none expected");
          errors++;
        end else begin
          want = expected_replies.pop_front();
          check_field("reply", 64'(want.reply), 64'(seen.reply));
          check_field("send_frame", 64'(want.send_frame), 64'(seen.send_frame));
          check_field("extended_id", 64'(want.extended_id), 64'(seen.extended_id));
          check_field("remote_request", 64'(want.remote_request),
                      64'(seen.remote_request));
          check_field("frame_id", 64'(want.frame_id), 64'(seen.frame_id));
          check_field("frame_length", 64'(want.frame_length), 64'(seen.frame_length));
          check_field("frame_data", want.frame_data, seen.frame_data);
          check_field("bus_action", 64'(want.bus_action), 64'(seen.bus_action));
          check_field("bitrate_index", 64'(want.bitrate_index), 64'(seen.bitrate_index));
          check_field("silent_mode", 64'(want.silent_mode), 64'(seen.silent_mode));
          check_field("loopback_mode", 64'(want.loopback_mode), 64'(seen.loopback_mode));
          check_field("timestamp_on", 64'(want.timestamp_on), 64'(seen.timestamp_on));
        end
      end
      if (rx_valid && rx_ready) begin
        if (take_byte(rx_byte, made)) expected_replies.push_back(made);
      end
      awaiting <= expected_replies.size();
    end
  end

endmodule

// File: tb/tb.sv
// Top of the serial CAN command line parser bench: clock, reset, byte stimulus and verdict.
// Depends on sccl_pkg, sccl_tb_pkg and sccl_reply_checker, which predicts and compares.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sccl_pkg::*;
  import sccl_tb_pkg::*;

  // Long receiver hold-off used to back the block up into its input queue.
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int SETTLE_TICKS = 64;

  logic        clk;
  logic        rst;
  logic        rx_valid;
  logic        rx_ready;
  logic [7:0]  rx_byte;
  logic        res_valid;
  logic        res_ready;
  logic [1:0]  reply;
  logic        send_frame;
  logic        extended_id;
  logic        remote_request;
  logic [31:0] frame_id;
  logic [3:0]  frame_length;
  logic [63:0] frame_data;
  logic [1:0]  bus_action;
  logic [3:0]  bitrate_index;
  logic        silent_mode;
  logic        loopback_mode;
  logic        timestamp_on;
  int unsigned mismatches;
  int unsigned awaiting;

  // Sender state; quiet and hold_req are shared with the receiver process.
  int unsigned sent;
  int unsigned gap_pct;
  bit          quiet;
  bit          hold_req;
  logic [7:0]  line_q [$];

  serial_can_command_line_parser dut (.*);
  sccl_reply_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard against a hung handshake; far beyond the slowest legitimate run.
  initial begin
    #4_000_000;
    $display("serial_can_command_line_parser verification failed");
    $finish;
  end

  // Offers one word and returns once it has been taken at a rising edge. Valid is only
  // lowered when an idle gap is inserted, so back-to-back words keep it high throughout.
  task automatic put_byte(input logic [7:0] b);
    if (!quiet && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    sent++;
  endtask

  task automatic put_line(input string s);
    int i;
    for (i = 0; i < s.len(); i++) put_byte(s[i]);
    put_byte(CH_CR);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'("0") + 8'(v);
    return (upper ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] random_print();
    return 8'($urandom_range(CH_FIRST_PRINT, CH_LAST_PRINT));
  endfunction

  function automatic logic [7:0] erase_char();
    return $urandom_range(0, 1) ? CH_BS : CH_DEL;
  endfunction

  // A frame line with random identifier, length and payload. Now and then the length
  // code is out of range, which the block must refuse.
  task automatic build_frame(input logic [7:0] cmd);
    bit          ext;
    bit          rtr;
    bit          upper;
    int unsigned nid;
    int unsigned dlc;
    int unsigned i;
    logic [31:0] id;
    ext   = (cmd == CMD_TX_EXT || cmd == CMD_RTR_EXT);
    rtr   = (cmd == CMD_RTR_EXT || cmd == CMD_RTR_STD);
    upper = 1'($urandom_range(0, 1));
    nid   = ext ? 8 : 3;
    case ($urandom_range(0, 7))
      0:       id = '0;
      1:       id = '1;
      default: id = $urandom;
    endcase
    line_q.push_back(cmd);
    for (i = nid; i > 0; i--) line_q.push_back(hex_char(id[4*(i-1) +: 4], upper));
    dlc = $urandom_range(0, MAX_DLC);
    if ($urandom_range(0, 15) == 0) dlc = $urandom_range(MAX_DLC + 1, 15);
    if (ext && !rtr) line_q.push_back(hex_char(4'(dlc), upper));
    else if (dlc > 9) line_q.push_back(random_print());
    else line_q.push_back(8'("0") + 8'(dlc));
    if (!rtr) begin
      for (i = 0; i < 2 * ((dlc > MAX_DLC) ? MAX_DLC : dlc); i++)
        line_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    end
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 4)) line_q.push_back(random_print());
  endtask

  // Spoils a well-formed line: cut it short, overwrite a character, or slip in a typo
  // that is erased straight away (which must leave the line as it was).
  task automatic mutate_line();
    int unsigned p;
    if (line_q.size() == 0) return;
    p = $urandom_range(0, line_q.size() - 1);
    case ($urandom_range(0, 2))
      0: repeat ($urandom_range(1, line_q.size())) void'(line_q.pop_back());
      1: line_q[p] = random_print();
      default: begin
        line_q.insert(p, erase_char());
        line_q.insert(p, random_print());
      end
    endcase
  endtask

  task automatic random_line();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  ch;
    line_q.delete();
    case ($urandom_range(0, 3))
      0, 1:    gap_pct = 0;
      2:       gap_pct = 15;
      default: gap_pct = 50;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      case ($urandom_range(0, 3))
        0:       build_frame(CMD_TX_EXT);
        1:       build_frame(CMD_TX_STD);
        2:       build_frame(CMD_RTR_EXT);
        default: build_frame(CMD_RTR_STD);
      endcase
    end else if (pick < 50) begin
      line_q.push_back($urandom_range(0, 1) ? CMD_BITRATE : CMD_BITRATE_ALT);
      if ($urandom_range(0, 4) != 0) line_q.push_back(8'("0") + 8'($urandom_range(0, MAX_BITRATE)));
      else line_q.push_back(random_print());
      if ($urandom_range(0, 5) == 0) line_q.push_back(random_print());
    end else if (pick < 58) begin
      case ($urandom_range(0, 3))
        0:       line_q.push_back(CMD_OPEN);
        1:       line_q.push_back(CMD_CLOSE);
        2:       line_q.push_back(CMD_LISTEN);
        default: line_q.push_back(CMD_LOOPBACK);
      endcase
      if ($urandom_range(0, 5) == 0) line_q.push_back(random_print());
    end else if (pick < 66) begin
      line_q.push_back(CMD_TIMESTAMP);
      if ($urandom_range(0, 4) != 0) line_q.push_back(8'("0") + 8'($urandom_range(0, 1)));
      else if ($urandom_range(0, 1) == 0) line_q.push_back(random_print());
      if ($urandom_range(0, 5) == 0) line_q.push_back(random_print());
    end else if (pick < 70) begin
      case ($urandom_range(0, 2))
        0:       line_q.push_back(CMD_ACCEPT_CODE);
        1:       line_q.push_back(CMD_ACCEPT_MASK);
        default: line_q.push_back(CMD_D_REFUSED);
      endcase
      repeat ($urandom_range(0, 8)) line_q.push_back(hex_char(4'($urandom_range(0, 15)), 1'b1));
    end else if (pick < 76) begin
      line_q.push_back(random_print());
      repeat ($urandom_range(0, 3)) line_q.push_back(random_print());
    end else if (pick < 80) begin
      // empty line: carriage return alone
    end else if (pick < 88) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom));
    end else if (pick < 92) begin
      // A partial line wiped by a control byte, then a short command.
      repeat ($urandom_range(1, 6)) line_q.push_back(random_print());
      do ch = 8'($urandom_range(0, 31)); while (ch == CH_BS || ch == CH_CR);
      line_q.push_back(ch);
      line_q.push_back($urandom_range(0, 1) ? CMD_OPEN : CMD_CLOSE);
    end else if (pick < 95) begin
      // Long line; now and then past the line capacity so that it is thrown away.
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(LINE_CAPACITY - 2, LINE_CAPACITY + 30)
                                      : $urandom_range(STORE_DEPTH - 4, 60);
      repeat (n) line_q.push_back(random_print());
    end else begin
      repeat ($urandom_range(1, 3)) line_q.push_back(erase_char());
      line_q.push_back($urandom_range(0, 1) ? CMD_LISTEN : CMD_LOOPBACK);
    end
    if (pick < 76 && $urandom_range(0, 7) == 0) mutate_line();
    line_q.push_back(CH_CR);
    foreach (line_q[k]) put_byte(line_q[k]);
  endtask

  // Receiver: short random stalls, stretches of steady acceptance, and one long
  // hold-off on request. In the closing part of the run it always accepts.
  initial begin
    int unsigned stall_pct;
    stall_pct = 20;
    res_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        res_ready <= 1'b1;
        @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
    end
  end

  initial begin
    int unsigned waited;
    sent     = 0;
    gap_pct  = 0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    rst      <= 1'b1;
    rx_valid <= 1'b0;
    rx_byte  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed lines: field extremes, each command and the awkward corners.
    put_line("");
    put_line("t7FF8FFFFFFFFFFFFFFFF");
    put_line("T1fffffff80011223344556677");
    put_line("TFFFFFFFF0");
    put_line("T00000000A");
    put_line("R123456789");
    put_line("R000000008");
    put_line("r7ff0");
    put_line("t12");
    put_line("t123x");
    put_line("t1234AB");
    put_line("t0001G0");
    put_line("S8");
    put_line("s0");
    put_line("S9");
    put_line("S80");
    put_line("Lxyz");
    put_line("l");
    put_line("O");
    put_line("C");
    put_line("Z0");
    put_line("Z2");
    put_line("Z1");
    put_line("M");
    put_line("m");
    put_line("D");
    put_line("V");
    // Erase on an empty line does nothing; a typo rubbed out with DEL leaves "O".
    put_byte(CH_BS);
    put_byte(CMD_OPEN);
    put_byte("x");
    put_byte(CH_DEL);
    put_byte(CH_CR);
    // A control byte that is not an edit throws the pending line away.
    put_byte(CMD_TIMESTAMP);
    put_byte("q");
    put_byte(CH_ESC);
    put_line("Z1");
    // Fill the line to capacity; the next printable word is dropped and clears it.
    repeat (LINE_CAPACITY) put_byte("x");
    put_byte("x");
    put_line("O");

    while (sent < 450) random_line();

    // Back-pressure: the receiver stops for a long while and the sender keeps going
    // until the block can take no more.
    gap_pct  = 0;
    hold_req = 1'b1;
    repeat (16) put_line("O");

    while (sent < 850) random_line();

    // Sender pause: nothing more until every reply word has come back.
    rx_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);

    while (sent < 1300) random_line();
    quiet = 1'b1;
    while (sent < 1450) random_line();

    rx_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (awaiting != 0 && waited < DRAIN_LIMIT);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (awaiting != 0) $error("%0d reply words never arrived", awaiting);

    if (mismatches == 0 && awaiting == 0) begin
      $display("serial_can_command_line_parser verification clean");
    end else begin
      $display("serial_can_command_line_parser verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/sccl_pkg.sv
rtl/sccl_front.sv
rtl/sccl_back.sv
rtl/serial_can_command_line_parser.sv
tb/sccl_reply_checker.sv
tb/tb.sv
